/* rtl/lrd_pkg.sv */
package lrd_pkg;

    localparam logic [2:0] CLS_CRC  = 3'd0;
    localparam logic [2:0] CLS_OP   = 3'd1;
    localparam logic [2:0] CLS_KLEN = 3'd2;
    localparam logic [2:0] CLS_KEY  = 3'd3;
    localparam logic [2:0] CLS_VLEN = 3'd4;
    localparam logic [2:0] CLS_VAL  = 3'd5;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_GOOD  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Classified byte handed from the parser to the checker.
    typedef struct packed {
        logic [7:0] data;
        logic       eol;
        logic [2:0] cls;
        logic [7:0] op;
        logic       last;
    } item_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

endpackage

/* rtl/lrd_front.sv */
module lrd_front
    import lrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_log,
    output logic       push_valid,
    input  logic       push_ready,
    output item_t      push_item
);

    typedef enum logic [5:0] {
        PH_CRC  = 6'b000001,
        PH_OP   = 6'b000010,
        PH_KLEN = 6'b000100,
        PH_KEY  = 6'b001000,
        PH_VLEN = 6'b010000,
        PH_VAL  = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic [7:0]  op_reg, op_next;
    logic [15:0] len;
    logic [2:0]  cls;
    logic [7:0]  item_op;
    logic        last;
    logic        take;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign take       = in_valid && push_ready;
    assign len        = {data_byte, len_low_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        len_low_next = len_low_reg;
        op_next      = op_reg;
        cls          = CLS_CRC;
        item_op      = op_reg;
        last         = 1'b0;
        unique case (phase_reg)
            PH_CRC:
            begin
                cls = CLS_CRC;
                if (count_reg == 16'd3)
                begin
                    count_next = 16'd0;
                    phase_next = PH_OP;
                end
                else
                begin
                    count_next = count_reg + 16'd1;
                end
            end
            PH_OP:
            begin
                cls        = CLS_OP;
                item_op    = data_byte;
                op_next    = data_byte;
                count_next = 16'd0;
                phase_next = PH_KLEN;
            end
            PH_KLEN, PH_VLEN:
            begin
                cls = (phase_reg == PH_KLEN) ? CLS_KLEN : CLS_VLEN;
                if (count_reg == 16'd0)
                begin
                    len_low_next = data_byte;
                    count_next   = 16'd1;
                end
                else
                begin
                    count_next = len;
                    if (phase_reg == PH_KLEN)
                    begin
                        phase_next = (len == 16'd0) ? PH_VLEN : PH_KEY;
                    end
                    else if (len == 16'd0)
                    begin
                        last = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_VAL;
                    end
                end
            end
            PH_KEY, PH_VAL:
            begin
                cls        = (phase_reg == PH_KEY) ? CLS_KEY : CLS_VAL;
                count_next = count_reg - 16'd1;
                if (count_reg == 16'd1)
                begin
                    if (phase_reg == PH_KEY)
                    begin
                        phase_next = PH_VLEN;
                    end
                    else
                    begin
                        last = 1'b1;
                    end
                end
            end
            default:
            begin
                // unreachable: restart framing with this byte as first crc byte
                cls          = CLS_CRC;
                item_op      = 8'd0;
                op_next      = 8'd0;
                len_low_next = 8'd0;
                count_next   = 16'd1;
                phase_next   = PH_CRC;
            end
        endcase
        if (last)
        begin
            phase_next   = PH_CRC;
            count_next   = 16'd0;
            op_next      = 8'd0;
            len_low_next = 8'd0;
        end
    end

    always_comb
    begin
        push_item.data = data_byte;
        push_item.eol  = end_of_log;
        push_item.cls  = cls;
        push_item.op   = item_op;
        push_item.last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CRC;
            count_reg   <= 16'd0;
            len_low_reg <= 8'd0;
            op_reg      <= 8'd0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            len_low_reg <= len_low_next;
            op_reg      <= op_next;
        end
    end

endmodule

/* rtl/lrd_queue.sv */
module lrd_queue
    import lrd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    item_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/lrd_back.sv */
module lrd_back
    import lrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  item_t      pop_item,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] byte_out,
    output logic [2:0] byte_class,
    output logic [7:0] op_code,
    output logic       record_end,
    output logic [1:0] record_status
);

    logic        stopped_reg, stopped_next;
    logic [31:0] stored_reg, stored_next;
    logic [31:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic [2:0]  class_reg;
    logic [7:0]  op_reg;
    logic [1:0]  status_reg, status_next;
    logic [31:0] crc_upd;
    logic        take;

    assign pop_ready     = !out_valid_reg || out_ready;
    assign take          = pop_valid && pop_ready;
    assign crc_upd       = crc32_byte(crc_reg, pop_item.data);

    assign out_valid     = out_valid_reg;
    assign byte_out      = byte_reg;
    assign byte_class    = class_reg;
    assign op_code       = op_reg;
    assign record_end    = (status_reg != ST_RUN);
    assign record_status = status_reg;

    always_comb
    begin
        stopped_next   = stopped_reg;
        stored_next    = stored_reg;
        crc_next       = crc_reg;
        status_next    = ST_RUN;
        out_valid_next = out_valid_reg && !out_ready;
        if (take && !stopped_reg)
        begin
            out_valid_next = 1'b1;
            if (pop_item.cls == CLS_CRC)
            begin
                // little-endian: after four bytes the first sits lowest
                stored_next = {pop_item.data, stored_reg[31:8]};
            end
            else
            begin
                crc_next = crc_upd;
            end
            if (pop_item.last)
            begin
                status_next = (~crc_upd == stored_reg) ? ST_GOOD : ST_BAD;
                crc_next    = CRC_INIT;
            end
            else if (pop_item.eol)
            begin
                status_next = ST_TRUNC;
            end
            if (status_next == ST_BAD || status_next == ST_TRUNC)
            begin
                stopped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg   <= pop_item.data;
            class_reg  <= pop_item.cls;
            op_reg     <= pop_item.op;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg   <= 1'b0;
            stored_reg    <= 32'd0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stopped_reg   <= stopped_next;
            stored_reg    <= stored_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/log_record_deframer_crc_check_core.sv */
// Log record deframer with CRC-32 check. Records arrive as a byte stream: a
// little-endian CRC-32, an op byte, a 16-bit little-endian key length and the
// key, a 16-bit value length and the value. Every byte comes back tagged with
// its class and, from the op byte on, the record's op; the last byte of a
// record carries good or crc mismatch, and a record cut short by end_of_log
// is marked truncated. After a bad or truncated record, input transfers are
// still taken but give no output until reset. Throughput is one byte per cycle
// while out_ready holds: the parser classifies a byte in the cycle it is
// taken, a QUEUE_DEPTH-entry queue decouples it from the checker, which runs
// one byte-wide CRC-32 update per cycle and fills the output register. Each
// byte is written into the queue and then into the output register.
module log_record_deframer_crc_check_core
    import lrd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_log,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] byte_out,
    output logic [2:0] byte_class,
    output logic [7:0] op_code,
    output logic       record_end,
    output logic [1:0] record_status
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    lrd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .end_of_log (end_of_log),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    lrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    lrd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_out      (byte_out),
        .byte_class    (byte_class),
        .op_code       (op_code),
        .record_end    (record_end),
        .record_status (record_status)
    );

endmodule
